// File: design/tps_pkg.sv
// Shared types and constants of the timed pattern sequencer.
// Holds command codes, field widths and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

  localparam int unsigned MAX_STATES_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 16;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned NUM_W     = 5;
  localparam int unsigned EIDX_W    = 4;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned OUT_W     = 8;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ATOMIC  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOPEND = 3'd5;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd7;

  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic div_load;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_tick;
    logic div_last;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

// File: design/tps_controller.sv
// Sequencing state machine of the timed pattern sequencer.
// Depends on tps_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tps_controller (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire tps_pkg::ctrl_status_t status_i,
  output tps_pkg::ctrl_cmd_t         cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_DIVL = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd_o.mem_rd = 1'b1;
        state_d = status_i.rd_tick ? ST_DIVL : ST_FIN;
      end
      ST_DIVL: begin
        cmd_o.div_load = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/tps_datapath.sv
// Datapath of the timed pattern sequencer: pattern table, period divider,
// sequencing state and the output register. Depends on tps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tps_datapath #(
  parameter int unsigned MAX_STATES = tps_pkg::MAX_STATES_DEF,
  parameter int unsigned TIME_BITS  = tps_pkg::TIME_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tps_pkg::MS_W-1:0]       cfg_wdata_i,
  input  wire logic [tps_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  wire logic [tps_pkg::CMD_W-1:0]      s_tuser_i,
  input  wire tps_pkg::ctrl_cmd_t             cmd_i,
  output tps_pkg::ctrl_status_t               status_o,
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  output logic [tps_pkg::M_TDATA_W-1:0]       m_tdata_o
);

  localparam int unsigned IDX_W  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int unsigned CNT_W  = tps_pkg::NUM_W;
  localparam int unsigned DCNT_W = $clog2(TIME_BITS);
  localparam int unsigned MS_W   = tps_pkg::MS_W;
  localparam int unsigned OUT_W  = tps_pkg::OUT_W;
  localparam int unsigned ENT_W  = TIME_BITS + OUT_W;

  // Configuration.
  logic [MS_W-1:0] tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= MS_W'(1);
    end else if (cfg_we_i) begin
      tick_q <= (cfg_wdata_i == '0) ? MS_W'(1) : cfg_wdata_i;
    end
  end

  // Captured input transfer.
  logic [tps_pkg::CMD_W-1:0]  cmd_q;
  logic                       bank_q;
  logic [tps_pkg::EIDX_W-1:0] eidx_q;
  logic [TIME_BITS-1:0]       etime_q;
  logic [OUT_W-1:0]           eout_q;
  logic [CNT_W-1:0]           num_q;

  logic [TIME_BITS+MS_W-1:0]  etime_ext;
  logic [CNT_W-1:0]           num_raw;
  logic [CNT_W-1:0]           num_clamp;

  assign etime_ext = {TIME_BITS'(0), s_tdata_i[20:5]};
  assign num_raw   = s_tdata_i[33:29];
  assign num_clamp = (9'(num_raw) > 9'(MAX_STATES)) ? CNT_W'(MAX_STATES) : num_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= s_tuser_i;
      bank_q  <= s_tdata_i[0];
      eidx_q  <= s_tdata_i[4:1];
      etime_q <= etime_ext[TIME_BITS-1:0];
      eout_q  <= s_tdata_i[28:21];
      num_q   <= num_clamp;
    end
  end

  // Sequencing state.
  logic             start_q, start_d;
  logic             active_q, active_d;
  logic             fin_q, fin_d;
  logic             atomic_q, atomic_d;
  logic             stopend_q, stopend_d;
  logic             act_bank_q, act_bank_d;
  logic             pend_bank_q, pend_bank_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pend_count_q, pend_count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [TIME_BITS-1:0] ticks_q, ticks_d;
  logic [OUT_W-1:0] cur_out_q, cur_out_d;

  // Pattern table.
  logic [ENT_W-1:0] mem_q [2][MAX_STATES];
  logic [ENT_W-1:0] rdata_q;
  logic [IDX_W+tps_pkg::EIDX_W-1:0] widx_ext;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;
  logic             rd_bank;
  logic [IDX_W-1:0] rd_idx;
  logic [TIME_BITS-1:0] rd_time;
  logic [OUT_W-1:0] rd_out;

  assign widx_ext = {IDX_W'(0), eidx_q};
  assign wr_idx   = widx_ext[IDX_W-1:0];
  assign wr_en    = cmd_i.commit && (cmd_q == tps_pkg::CMD_WRITE) &&
                    (9'(eidx_q) < 9'(MAX_STATES));
  assign rd_bank  = (cmd_q == tps_pkg::CMD_LOAD) ? bank_q : act_bank_q;
  assign rd_idx   = (cmd_q == tps_pkg::CMD_LOAD) ? IDX_W'(0) : idx_q;
  assign rd_time  = rdata_q[ENT_W-1:OUT_W];
  assign rd_out   = rdata_q[OUT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[bank_q][wr_idx] <= {etime_q, eout_q};
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[rd_bank][rd_idx];
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [MS_W-1:0]      rem_q;
  logic [TIME_BITS-1:0] quo_q;
  logic [DCNT_W-1:0]    dcnt_q;
  logic [MS_W:0]        trial;
  logic [MS_W:0]        diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[TIME_BITS-1]};
  assign ge    = trial >= {1'b0, tick_q};
  assign diff  = trial - {1'b0, tick_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= '0;
      quo_q  <= rd_time;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
      quo_q  <= {quo_q[TIME_BITS-2:0], ge};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
  end

  // Item update.
  logic [TIME_BITS-1:0] period;
  logic [TIME_BITS-1:0] tl;
  logic [TIME_BITS-1:0] tl_dec;
  logic [IDX_W:0]       idx_inc;
  logic                 last_state;
  logic                 changed;
  logic                 done;

  assign period     = (quo_q == '0) ? TIME_BITS'(1) : quo_q;
  assign idx_inc    = {1'b0, idx_q} + (IDX_W + 1)'(1);
  assign last_state = 9'(idx_inc) >= 9'(count_q);
  assign tl         = start_q ? period : ticks_q;
  assign tl_dec     = tl - TIME_BITS'(1);

  always_comb begin
    start_d      = start_q;
    active_d     = active_q;
    fin_d        = fin_q;
    atomic_d     = atomic_q;
    stopend_d    = stopend_q;
    act_bank_d   = act_bank_q;
    pend_bank_d  = pend_bank_q;
    count_d      = count_q;
    pend_count_d = pend_count_q;
    idx_d        = idx_q;
    ticks_d      = ticks_q;
    cur_out_d    = cur_out_q;
    changed      = 1'b0;
    done         = 1'b0;
    case (cmd_q)
      tps_pkg::CMD_TICK: begin
        if (start_q) begin
          start_d   = 1'b0;
          active_d  = 1'b1;
          ticks_d   = period;
          cur_out_d = rd_out;
          changed   = 1'b1;
        end
        if (start_q || active_q) begin
          ticks_d = tl_dec;
          if (tl_dec == '0) begin
            if (last_state) begin
              fin_d = 1'b1;
              idx_d = '0;
              done  = 1'b1;
              if (atomic_q) begin
                atomic_d   = 1'b0;
                act_bank_d = pend_bank_q;
                count_d    = pend_count_q;
              end
              if (stopend_q) begin
                stopend_d = 1'b0;
                active_d  = 1'b0;
              end else begin
                start_d = 1'b1;
              end
            end else begin
              idx_d   = idx_inc[IDX_W-1:0];
              start_d = 1'b1;
            end
          end
        end
      end
      tps_pkg::CMD_WRITE: begin
      end
      tps_pkg::CMD_LOAD: begin
        if (num_q != '0) begin
          active_d   = 1'b0;
          fin_d      = 1'b0;
          atomic_d   = 1'b0;
          start_d    = 1'b1;
          act_bank_d = bank_q;
          count_d    = num_q;
          ticks_d    = '0;
          idx_d      = '0;
          cur_out_d  = rd_out;
        end
      end
      tps_pkg::CMD_ATOMIC: begin
        if (num_q != '0) begin
          pend_bank_d  = bank_q;
          pend_count_d = num_q;
          atomic_d     = 1'b1;
        end
      end
      tps_pkg::CMD_START: begin
        if (count_q != '0) begin
          start_d   = 1'b1;
          stopend_d = 1'b0;
        end
      end
      tps_pkg::CMD_STOPEND: begin
        stopend_d = 1'b1;
      end
      tps_pkg::CMD_STOP: begin
        start_d  = 1'b0;
        active_d = 1'b0;
      end
      tps_pkg::CMD_CLEAR: begin
        fin_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= 1'b0;
      active_q     <= 1'b0;
      fin_q        <= 1'b0;
      atomic_q     <= 1'b0;
      stopend_q    <= 1'b0;
      act_bank_q   <= 1'b0;
      pend_bank_q  <= 1'b0;
      count_q      <= '0;
      pend_count_q <= '0;
      idx_q        <= '0;
      ticks_q      <= '0;
      cur_out_q    <= '0;
    end else if (cmd_i.commit) begin
      start_q      <= start_d;
      active_q     <= active_d;
      fin_q        <= fin_d;
      atomic_q     <= atomic_d;
      stopend_q    <= stopend_d;
      act_bank_q   <= act_bank_d;
      pend_bank_q  <= pend_bank_d;
      count_q      <= count_d;
      pend_count_q <= pend_count_d;
      idx_q        <= idx_d;
      ticks_q      <= ticks_d;
      cur_out_q    <= cur_out_d;
    end
  end

  // Output register.
  logic             out_valid_q;
  logic [OUT_W-1:0] o_pat_q;
  logic             o_chg_q;
  logic             o_done_q;
  logic             o_run_q;
  logic             o_fin_q;
  logic             out_free;

  assign out_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      o_pat_q  <= cur_out_d;
      o_chg_q  <= changed;
      o_done_q <= done;
      o_run_q  <= active_d;
      o_fin_q  <= fin_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0, o_fin_q, o_run_q, o_done_q, o_chg_q, o_pat_q};

  assign status_o.rd_tick  = (cmd_q == tps_pkg::CMD_TICK) && start_q;
  assign status_o.div_last = dcnt_q == DCNT_W'(TIME_BITS - 1);
  assign status_o.out_free = out_free;

  // A result is only written into a free output slot.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> out_free)
    else $error("result committed over an untaken result");

  // The divider remainder stays below the divisor while it iterates.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < tick_q))
    else $error("divider remainder out of range");

  // A pending or running pattern always points inside its loaded length.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q || active_q) |-> (9'(idx_q) < 9'(count_q)))
    else $error("state index beyond pattern length");

  // A completed pattern reports the finished flag in the same result.
  a_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_done_q) |-> o_fin_q)
    else $error("pattern done without finished flag");

endmodule

`default_nettype wire

// File: design/timed_pattern_sequencer.sv
// Timed pattern sequencer: a tick that enters a new state passes from decode through the
// divider load and the period division (one quotient bit per cycle) to the result state,
// and every other command goes from decode straight to it; one item is worked on at a time.
// The next item is taken while an earlier result still waits in the output register.
// Reset (asynchronous, active low) stops the pattern, clears all flags and counters and
// sets tick_ms to one; the pattern table holds no defined contents until written.
`timescale 1ns / 1ps
`default_nettype none

module timed_pattern_sequencer #(
  parameter int unsigned MAX_STATES = tps_pkg::MAX_STATES_DEF,
  parameter int unsigned TIME_BITS  = tps_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tps_pkg::MS_W-1:0]      cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // bank, entry_index, entry_time_ms, entry_output, num_states, zero fill.
  input  wire logic [tps_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // cmd.
  input  wire logic [tps_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pattern_output, output_changed, pattern_done, running, finished, zero fill.
  output logic [tps_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  tps_pkg::ctrl_cmd_t    ctrl_cmd;
  tps_pkg::ctrl_status_t ctrl_status;

  tps_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (ctrl_status),
    .cmd_o      (ctrl_cmd)
  );

  tps_datapath #(
    .MAX_STATES (MAX_STATES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_i       (ctrl_cmd),
    .status_o    (ctrl_status),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: tb/timed_pattern_sequencer_test.sv
// Testbench for timed_pattern_sequencer: directed command checks, then random phases
// at several tick_ms settings, with results checked against a built-in predictor.
// Depends on tps_pkg and the timed_pattern_sequencer RTL.
`timescale 1ns / 1ps

module timed_pattern_sequencer_test;
  import tps_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] pattern;
    logic             changed;
    logic             done;
    logic             running;
    logic             finished;
  } step_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [MS_W-1:0]      cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [CMD_W-1:0]     s_axis_tuser  = CMD_TICK;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire  [M_TDATA_W-1:0] m_axis_tdata;

  // Sequencer state as the testbench predicts it.
  logic [MS_W-1:0]   tbl_ms     [2][MAX_STATES_DEF];
  logic [OUT_W-1:0]  tbl_out    [2][MAX_STATES_DEF];
  bit                filled     [2][MAX_STATES_DEF];
  logic              run_bank      = 1'b0;
  logic [NUM_W-1:0]  run_len       = '0;
  logic              queued_bank   = 1'b0;
  logic [NUM_W-1:0]  queued_len    = '0;
  logic [EIDX_W-1:0] step_idx      = '0;
  logic [MS_W-1:0]   ticks_rem     = '0;
  logic [OUT_W-1:0]  cur_out       = '0;
  bit                f_start       = 1'b0;
  bit                f_active      = 1'b0;
  bit                f_finished    = 1'b0;
  bit                f_swap        = 1'b0;
  bit                f_stop_at_end = 1'b0;
  logic [MS_W-1:0]   ms_per_tick   = 16'd1;

  step_result_t expected_results[$];
  int unsigned  error_count   = 0;
  int unsigned  src_idle_pct  = 0;
  int unsigned  sink_idle_pct = 0;

  timed_pattern_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic step_result_t predict_step(input logic [CMD_W-1:0] cmd, input logic bank,
                                                input logic [EIDX_W-1:0] idx,
                                                input logic [MS_W-1:0] ms,
                                                input logic [OUT_W-1:0] outb,
                                                input logic [NUM_W-1:0] num);
    step_result_t     r;
    logic [MS_W-1:0]  period;
    logic [NUM_W-1:0] len;
    r   = '0;
    len = (num > NUM_W'(MAX_STATES_DEF)) ? NUM_W'(MAX_STATES_DEF) : num;
    case (cmd)
      CMD_TICK: begin
        if (f_start) begin
          period = tbl_ms[run_bank][step_idx] / ms_per_tick;
          f_start = 1'b0;
          if (period == '0) period = MS_W'(1);
          ticks_rem = period;
          cur_out = tbl_out[run_bank][step_idx];
          f_active = 1'b1;
          r.changed = 1'b1;
        end
        if (f_active) begin
          ticks_rem = ticks_rem - MS_W'(1);
          if (ticks_rem == '0) begin
            if (({1'b0, step_idx} + 5'd1) >= run_len) begin
              f_finished = 1'b1;
              step_idx = '0;
              r.done = 1'b1;
              if (f_swap) begin
                f_swap = 1'b0;
                run_bank = queued_bank;
                run_len = queued_len;
              end
              if (f_stop_at_end) begin
                f_stop_at_end = 1'b0;
                f_active = 1'b0;
              end else begin
                f_start = 1'b1;
              end
            end else begin
              step_idx = step_idx + EIDX_W'(1);
              f_start = 1'b1;
            end
          end
        end
      end
      CMD_WRITE: begin
        tbl_ms[bank][idx] = ms;
        tbl_out[bank][idx] = outb;
        filled[bank][idx] = 1'b1;
      end
      CMD_LOAD: begin
        if (len != '0) begin
          f_active = 1'b0;
          f_finished = 1'b0;
          f_swap = 1'b0;
          run_bank = bank;
          run_len = len;
          ticks_rem = '0;
          step_idx = '0;
          cur_out = tbl_out[bank][0];
          f_start = 1'b1;
        end
      end
      CMD_ATOMIC: begin
        if (len != '0) begin
          queued_bank = bank;
          queued_len = len;
          f_swap = 1'b1;
        end
      end
      CMD_START: begin
        if (run_len != '0) begin
          f_start = 1'b1;
          f_stop_at_end = 1'b0;
        end
      end
      CMD_STOPEND: f_stop_at_end = 1'b1;
      CMD_STOP: begin
        f_start = 1'b0;
        f_active = 1'b0;
      end
      CMD_CLEAR: f_finished = 1'b0;
      default: ;
    endcase
    r.pattern  = cur_out;
    r.running  = f_active;
    r.finished = f_finished;
    return r;
  endfunction

  // Loads may only select entries that have been written, so lengths stay within the
  // written run of entries starting at index 0.
  function automatic int written_prefix(input logic bank);
    int n;
    n = 0;
    while (n < MAX_STATES_DEF && filled[bank][EIDX_W'(n)]) n++;
    return n;
  endfunction

  function automatic logic [MS_W-1:0] pick_duration();
    int unsigned d;
    if (ms_per_tick >= 16'd4096 && $urandom_range(0, 3) == 0) return MS_W'($urandom);
    d = int'(ms_per_tick) * $urandom_range(0, 3) + $urandom_range(0, int'(ms_per_tick) - 1);
    return (d > 65535) ? 16'hFFFF : MS_W'(d);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < 50) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    end
    error_count++;
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic bank,
                           input logic [EIDX_W-1:0] idx, input logic [MS_W-1:0] ms,
                           input logic [OUT_W-1:0] outb, input logic [NUM_W-1:0] num);
    expected_results.push_back(predict_step(cmd, bank, idx, ms, outb, num));
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, num, outb, ms, idx, bank};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic set_tick_ms(input logic [MS_W-1:0] value);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ms_per_tick = (value == 0) ? 16'd1 : value;
  endtask

  task automatic test_commands_without_pattern();
    send_item(CMD_START, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_TICK, 1'b1, 4'hF, 16'hFFFF, 8'hFF, 5'd31);
    send_item(CMD_LOAD, 1'b1, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_ATOMIC, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_STOP, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_CLEAR, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
  endtask

  task automatic test_pattern_run();
    send_item(CMD_WRITE, 1'b0, 4'd0, 16'd0, 8'hFF, 5'd0);
    send_item(CMD_WRITE, 1'b0, 4'd1, 16'd2, 8'h00, 5'd0);
    send_item(CMD_WRITE, 1'b0, 4'd2, 16'd1, 8'h5A, 5'd0);
    send_item(CMD_WRITE, 1'b1, 4'd0, 16'd3, 8'hA5, 5'd0);
    send_item(CMD_LOAD, 1'b0, 4'd0, 16'd0, 8'd0, 5'd3);
    repeat (4) send_item(CMD_TICK, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
  endtask

  task automatic test_atomic_and_stop();
    send_item(CMD_ATOMIC, 1'b1, 4'd0, 16'd0, 8'd0, 5'd1);
    send_item(CMD_STOPEND, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    repeat (4) send_item(CMD_TICK, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_CLEAR, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_START, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_TICK, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_STOP, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
    send_item(CMD_TICK, 1'b0, 4'd0, 16'd0, 8'd0, 5'd0);
  endtask

  task automatic test_random_phase(input logic [MS_W-1:0] tick_value, input int unsigned count,
                                   input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned       sel;
    int                pre;
    logic              b;
    logic [CMD_W-1:0]  cmd;
    logic [NUM_W-1:0]  n;
    logic [EIDX_W-1:0] idx;
    set_tick_ms(tick_value);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      b   = 1'($urandom_range(0, 1));
      pre = written_prefix(b);
      if (sel < 56) cmd = CMD_TICK;
      else if (sel < 73) cmd = CMD_WRITE;
      else if (sel < 78) cmd = CMD_LOAD;
      else if (sel < 84) cmd = CMD_ATOMIC;
      else if (sel < 89) cmd = CMD_START;
      else if (sel < 93) cmd = CMD_STOPEND;
      else if (sel < 96) cmd = CMD_STOP;
      else cmd = CMD_CLEAR;
      if ((cmd == CMD_LOAD || cmd == CMD_ATOMIC) && pre == 0) cmd = CMD_WRITE;
      n = NUM_W'($urandom);
      if (cmd == CMD_LOAD || cmd == CMD_ATOMIC) begin
        if ($urandom_range(0, 19) == 0) n = '0;
        else if (pre == MAX_STATES_DEF) n = NUM_W'($urandom_range(1, 31));
        else n = NUM_W'($urandom_range(1, pre));
      end
      if (cmd == CMD_WRITE) begin
        if (pre < MAX_STATES_DEF && $urandom_range(0, 1) == 0) idx = EIDX_W'(pre);
        else idx = EIDX_W'($urandom);
        send_item(cmd, b, idx, pick_duration(), OUT_W'($urandom), n);
      end else begin
        send_item(cmd, b, EIDX_W'($urandom), MS_W'($urandom), OUT_W'($urandom), n);
      end
    end
  endtask

  always @(posedge clk_i) begin
    step_result_t got;
    step_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pattern  = m_axis_tdata[7:0];
      got.changed  = m_axis_tdata[8];
      got.done     = m_axis_tdata[9];
      got.running  = m_axis_tdata[10];
      got.finished = m_axis_tdata[11];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_axis_tdata), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.pattern !== want.pattern)
          report_mismatch("pattern_output", 32'(got.pattern), 32'(want.pattern));
        if (got.changed !== want.changed)
          report_mismatch("output_changed", 32'(got.changed), 32'(want.changed));
        if (got.done !== want.done)
          report_mismatch("pattern_done", 32'(got.done), 32'(want.done));
        if (got.running !== want.running)
          report_mismatch("running", 32'(got.running), 32'(want.running));
        if (got.finished !== want.finished)
          report_mismatch("finished", 32'(got.finished), 32'(want.finished));
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    test_commands_without_pattern();
    test_pattern_run();
    test_atomic_and_stop();
    // Settings rise from phase to phase so that durations written earlier stay short.
    test_random_phase(16'd0, 150, 30, 30);
    test_random_phase(16'd2, 170, 0, 0);
    test_random_phase(MS_W'($urandom_range(3, 200)), 170, 20, 40);
    test_random_phase(MS_W'($urandom_range(1000, 20000)), 170, 40, 10);
    test_random_phase(16'hFFFF, 190, 0, 0);
    wait_for_drain();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
